// ===== sv/sms_pkg.sv =====
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants of the signature match scanner: stream word
// layouts, configuration register indexes and region codes.
// ----------------------------------------------------------------------------
package sms_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int SIG_WORDS   = 4;
    localparam int SIG_BYTES   = 8 * SIG_WORDS;
    localparam int LEN_W       = 6;
    localparam int OFFSET_W    = 32;

    // file length split into hundreds, a fifth of each hundred
    localparam int CENT        = 100;
    localparam int FIFTH_STEP  = 20;
    localparam int REM_W       = $clog2(CENT);

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    // register indexes
    localparam cfg_index_t CFG_SIG_LENGTH = 3'd0;
    localparam cfg_index_t CFG_SIG_WORD_0 = 3'd1;
    localparam cfg_index_t CFG_SIG_WORD_1 = 3'd2;
    localparam cfg_index_t CFG_SIG_WORD_2 = 3'd3;
    localparam cfg_index_t CFG_SIG_WORD_3 = 3'd4;

    // region codes
    typedef logic [1:0] region_t;
    localparam region_t REGION_NONE  = 2'd0;
    localparam region_t REGION_FIRST = 2'd1;
    localparam region_t REGION_LAST  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } sms_scan_t;

    typedef struct packed {
        logic                infected;
        logic [OFFSET_W-1:0] match_offset;
        region_t             region;
    } sms_result_t;

endpackage

// ===== sv/sms_chan_if.sv =====
// ----------------------------------------------------------------------------
// sms_chan_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface sms_chan_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== sv/signature_match_scanner.sv =====
// ----------------------------------------------------------------------------
// signature_match_scanner
// Searches a byte stream for a configured signature of up to 32 bytes and
// reports the first match of each file on its last byte.
// ----------------------------------------------------------------------------
// Usage:
//   scan   : one file byte per word, last_byte marks the end of the file
//   result : one word per file: infected flag, offset of the first match
//            start and the region code (first or last fifth of the file)
//   cfg    : write port, sig_length at index 0, signature words at 1..4;
//            write only while no file word is in flight
// Throughput: one byte per clock unless a last byte waits on a held result;
//   the window compare against the whole signature is a single parallel
//   compare behind the input register.
// Path: a last byte passes the input register, then the result register,
//   where the result word is held until it is taken.
// Reset: clears the signature registers, the window, the byte counter and
//   the match record; no result is pending.
// Stall: a held result word does not block ordinary bytes; only the next
//   last byte waits in the input register until the result is taken, and
//   scan.ready drops behind it.
// ----------------------------------------------------------------------------
module signature_match_scanner #(
    parameter int MAX_SIG    = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  sms_pkg::cfg_index_t cfg_index,
    input  sms_pkg::cfg_data_t  cfg_wdata,
    sms_chan_if.sink           scan,
    sms_chan_if.source         result
);

    import sms_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int SHIFT_W = LEN_W + 3;

    // configuration registers
    logic [LEN_W-1:0]                      sig_length_reg;
    logic [SIG_WORDS-1:0][CFG_DATA_W-1:0]  sig_word_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // stream state
    logic [MAX_SIG-1:0][7:0]   win_reg;
    logic [COUNT_BITS-1:0]     count_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [COUNT_BITS-1:0]     fifth_reg;
    logic [COUNT_BITS-1:0]     tail_reg;
    logic                      seen_reg;
    logic [COUNT_BITS-1:0]     offset_reg;

    // result register
    logic        out_valid_reg;
    sms_result_t out_reg;

    logic                      advance;
    logic [MAX_SIG-1:0][7:0]   win_next;
    logic [COUNT_BITS-1:0]     count_next;
    logic [REM_W-1:0]          rem_next;
    logic [COUNT_BITS-1:0]     fifth_next;
    logic [COUNT_BITS-1:0]     tail_next;
    logic                      seen_next;
    logic [COUNT_BITS-1:0]     offset_next;
    logic [SIG_BYTES-1:0][7:0] sig_bytes;
    logic [MAX_SIG-1:0][7:0]   sig_rev;
    logic [MAX_SIG-1:0][7:0]   expected;
    logic [LEN_W-1:0]          shift_bytes;
    logic [SHIFT_W-1:0]        shift_bits;
    logic [MAX_SIG-1:0]        byte_hit;
    logic                      len_ok;
    logic                      hit_now;
    logic [COUNT_BITS-1:0]     cand_offset;
    region_t                   region_next;

    // handshakes
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || result.ready);
    assign scan.ready    = !in_valid_reg || advance;
    assign result.valid  = out_valid_reg;
    assign result.payload = out_reg;

    // window with the newest byte at position 0
    always_comb
    begin
        win_next[0] = in_byte_reg;
        for (int j = 1; j < MAX_SIG; j++)
        begin
            win_next[j] = win_reg[j-1];
        end
    end

    // signature aligned so that window position j meets byte len-1-j
    assign sig_bytes   = sig_word_reg;
    assign shift_bytes = LEN_W'(MAX_SIG) - sig_length_reg;
    assign shift_bits  = {shift_bytes, 3'b000};

    always_comb
    begin
        for (int j = 0; j < MAX_SIG; j++)
        begin
            sig_rev[j] = sig_bytes[MAX_SIG-1-j];
        end
        expected = sig_rev >> shift_bits;
        for (int j = 0; j < MAX_SIG; j++)
        begin
            byte_hit[j] = (LEN_W'(j) >= sig_length_reg) || (win_next[j] == expected[j]);
        end
    end

    // byte count with running hundreds remainder, fifth and tail start
    always_comb
    begin
        count_next = count_reg;
        rem_next   = rem_reg;
        fifth_next = fifth_reg;
        tail_next  = tail_reg;
        if (count_reg != COUNT_MAX)
        begin
            count_next = count_reg + 1'b1;
            if (rem_reg == REM_W'(CENT - 1))
            begin
                rem_next   = '0;
                fifth_next = fifth_reg + COUNT_BITS'(FIFTH_STEP);
                tail_next  = tail_reg - COUNT_BITS'(FIFTH_STEP - 1);
            end
            else
            begin
                rem_next  = rem_reg + 1'b1;
                tail_next = tail_reg + 1'b1;
            end
        end
    end

    // first match record and region decision
    assign len_ok      = (sig_length_reg != '0) && (sig_length_reg <= LEN_W'(MAX_SIG));
    assign cand_offset = count_next - COUNT_BITS'(sig_length_reg);
    assign hit_now     = !seen_reg && len_ok && (count_next >= COUNT_BITS'(sig_length_reg))
                         && (&byte_hit);
    assign seen_next   = seen_reg || hit_now;
    assign offset_next = hit_now ? cand_offset : offset_reg;

    always_comb
    begin
        region_next = REGION_NONE;
        if (seen_next)
        begin
            if (offset_next < fifth_next)
            begin
                region_next = REGION_FIRST;
            end
            else if (offset_next >= tail_next)
            begin
                region_next = REGION_LAST;
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_length_reg <= '0;
            sig_word_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIG_LENGTH: sig_length_reg  <= cfg_wdata[LEN_W-1:0];
                CFG_SIG_WORD_0: sig_word_reg[0] <= cfg_wdata;
                CFG_SIG_WORD_1: sig_word_reg[1] <= cfg_wdata;
                CFG_SIG_WORD_2: sig_word_reg[2] <= cfg_wdata;
                CFG_SIG_WORD_3: sig_word_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register, stream state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_byte_reg   <= '0;
            in_last_reg   <= 1'b0;
            win_reg       <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            fifth_reg     <= '0;
            tail_reg      <= '0;
            seen_reg      <= 1'b0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (scan.ready)
            begin
                in_valid_reg <= scan.valid;
                in_byte_reg  <= scan.payload.data_byte;
                in_last_reg  <= scan.payload.last_byte;
            end

            // result valid: set by a last byte, cleared when taken
            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                if (in_last_reg)
                begin
                    // end of file: report and start over
                    win_reg       <= '0;
                    count_reg     <= '0;
                    rem_reg       <= '0;
                    fifth_reg     <= '0;
                    tail_reg      <= '0;
                    seen_reg      <= 1'b0;
                    offset_reg    <= '0;
                end
                else
                begin
                    win_reg    <= win_next;
                    count_reg  <= count_next;
                    rem_reg    <= rem_next;
                    fifth_reg  <= fifth_next;
                    tail_reg   <= tail_next;
                    seen_reg   <= seen_next;
                    offset_reg <= offset_next;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_reg.infected     <= seen_next;
            out_reg.match_offset <= seen_next ? OFFSET_W'(offset_next) : '0;
            out_reg.region       <= region_next;
        end
    end

endmodule

// ===== sv/sms_checker.sv =====
// ----------------------------------------------------------------------------
// sms_checker
// Port-level checks of the signature match scanner: result channel holds,
// consistency of a clean result and the timing of result words.
// ----------------------------------------------------------------------------
module sms_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     scan_valid,
    input logic                     scan_ready,
    input logic                     scan_last,
    input logic                     result_valid,
    input logic                     result_ready,
    input logic                     result_infected,
    input logic [sms_pkg::OFFSET_W-1:0] result_offset,
    input sms_pkg::region_t         result_region
);

    import sms_pkg::*;

    // a stalled result word stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(result_infected) && $stable(result_offset) && $stable(result_region))
        else $error("result payload changed while stalled");

    // a clean file reports offset zero and no region
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_infected |->
            (result_offset == '0) && (result_region == REGION_NONE))
        else $error("clean result carries offset or region");

    // a fresh result word follows a last byte accepted on the scan port
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(scan_valid && scan_ready && scan_last, 2))
        else $error("result word without a last byte");

endmodule

bind signature_match_scanner sms_checker u_sms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .scan_valid     (scan.valid),
    .scan_ready     (scan.ready),
    .scan_last      (scan.payload.last_byte),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_infected(result.payload.infected),
    .result_offset  (result.payload.match_offset),
    .result_region  (result.payload.region)
);
